// ===== src/oled_dpf_pkg.sv =====
// Shared constants, types and codes of the dirty-page flusher.
`default_nettype none
package oled_dpf_pkg;

  localparam int PAGES       = 4;
  localparam int PAGE_BYTES  = 128;
  localparam int CHUNK_BYTES = 64;

  localparam int STORE_DEPTH = PAGES * PAGE_BYTES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int COL_W       = $clog2(PAGE_BYTES);
  localparam int K_W         = $clog2(CHUNK_BYTES + 1);
  localparam int CMD_BYTES   = 6;
  localparam int CMD_W       = $clog2(CMD_BYTES + 1);

  localparam int COMMAND_W   = 2;
  localparam int PAGE_IDX_W  = 2;
  localparam int COLUMN_W    = 7;
  localparam int PIXEL_W     = 8;
  localparam int DEV_W       = 7;
  localparam int KIND_W      = 2;
  localparam int MASK_W      = 4;

  localparam logic [DEV_W-1:0] DEV_RESET = DEV_W'(60);

  localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
  localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
  localparam logic [7:0] CTRL_DATA     = 8'h40;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [COMMAND_W-1:0] {
    OP_LOAD       = 2'd0,
    OP_END_FRAME  = 2'd1,
    OP_PULL       = 2'd2,
    OP_INVALIDATE = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_CMD  = 2'd0,
    KIND_CTRL = 2'd1,
    KIND_DATA = 2'd2
  } kind_e;

  // Classified item as it sits in the queue.
  typedef struct packed {
    op_e                op;
    logic               load_ok;
    logic [ADDR_W-1:0]  addr;
    logic [PIXEL_W-1:0] pixel;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage
`default_nettype wire

// ===== src/oled_dirty_page_flusher_top.sv =====
// Top level of the dirty-page flusher: front queue, execution engine, config register.
`default_nettype none
// Every accepted command beat yields exactly one result beat, shown on the result
// ports for a single cycle under res_strobe_o; the receiver cannot stall, so it must
// take each one. A two-entry queue sits between the command port and the engine, and
// busy_o rises only when that queue is full. The engine handles a load, an
// invalidate, a busy or idle pull, and a pull that returns an addressing command or
// the 0x40 control byte straight from its idle state; a pull that returns a data byte
// does a registered frame-store read, then the shadow write; an end of frame with a
// valid shadow sweeps all PAGES*PAGE_BYTES addresses (512 at the default size) over
// the single read port of each store; with an invalid shadow it marks every page dirty.
// Results come back in command order. The device address register may be written at
// any time the block is idle; cfg_ready_o is always high.
module oled_dirty_page_flusher_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [oled_dpf_pkg::COMMAND_W-1:0]  command_i,
  input  wire logic [oled_dpf_pkg::PAGE_IDX_W-1:0] page_index_i,
  input  wire logic [oled_dpf_pkg::COLUMN_W-1:0]   column_index_i,
  input  wire logic [oled_dpf_pkg::PIXEL_W-1:0]    pixel_byte_i,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [oled_dpf_pkg::DEV_W-1:0]      cfg_data_i,
  output logic                                     res_strobe_o,
  output logic                                     out_valid_o,
  output logic [oled_dpf_pkg::KIND_W-1:0]          out_kind_o,
  output logic [7:0]                               out_byte_o,
  output logic                                     out_last_o,
  output logic [oled_dpf_pkg::MASK_W-1:0]          dirty_mask_o,
  output logic                                     busy_res_o
);
  import oled_dpf_pkg::*;

  head_t             head;
  logic              pop;
  logic [DEV_W-1:0]  dev_addr_q, dev_addr_d;

  assign cfg_ready_o = 1'b1;
  assign dev_addr_d  = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : dev_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEV_RESET;
    end else begin
      dev_addr_q <= dev_addr_d;
    end
  end

  oled_dpf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .page_index_i   (page_index_i),
    .column_index_i (column_index_i),
    .pixel_byte_i   (pixel_byte_i),
    .pop_i          (pop),
    .head_o         (head)
  );

  oled_dpf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .dev_addr_i   (dev_addr_q),
    .res_strobe_o (res_strobe_o),
    .out_valid_o  (out_valid_o),
    .out_kind_o   (out_kind_o),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .dirty_mask_o (dirty_mask_o),
    .busy_res_o   (busy_res_o)
  );

  // A beat with no bus byte carries zeros in the byte fields.
  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !out_valid_o) |-> (out_kind_o == KIND_CMD && out_byte_o == 8'h00
                                        && !out_last_o))
    else $error("non-valid result carries byte fields");

  // Busy can only drop on a bus byte if that byte finished the last dirty page.
  a_drop_on_last_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && out_valid_o && !busy_res_o) |-> (out_kind_o == KIND_DATA && out_last_o))
    else $error("pending pages cleared by a byte that is not a page end");

  // Control bytes always carry the data-stream opener.
  a_ctrl_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && out_valid_o && out_kind_o == KIND_CTRL) |->
      (out_byte_o == CTRL_DATA && !out_last_o))
    else $error("control beat with wrong byte or last flag");

  // Engine never pops an empty queue head.
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("engine popped with nothing queued");

endmodule
`default_nettype wire

// ===== src/oled_dpf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module oled_dpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== src/oled_dpf_front.sv =====
// Front end: takes command beats, classifies them and queues them for the engine.
`default_nettype none
module oled_dpf_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [oled_dpf_pkg::COMMAND_W-1:0] command_i,
  input  wire logic [oled_dpf_pkg::PAGE_IDX_W-1:0] page_index_i,
  input  wire logic [oled_dpf_pkg::COLUMN_W-1:0]  column_index_i,
  input  wire logic [oled_dpf_pkg::PIXEL_W-1:0]   pixel_byte_i,
  input  wire logic                               pop_i,
  output oled_dpf_pkg::head_t                     head_o
);
  import oled_dpf_pkg::*;

  item_t             q_mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  item_t             item;
  logic              push;
  logic              pop;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    item.op      = op_e'(command_i);
    item.load_ok = (int'(page_index_i) < PAGES) && (int'(column_index_i) < PAGE_BYTES);
    item.addr    = ADDR_W'(int'(page_index_i) * PAGE_BYTES + int'(column_index_i));
    item.pixel   = pixel_byte_i;
  end

  assign busy_o = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign push   = start_i && !busy_o;
  assign pop    = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= item;
    end
  end

endmodule
`default_nettype wire

// ===== src/oled_dpf_back.sv =====
// Back end: executes queued items against the frame and shadow stores.
`default_nettype none
module oled_dpf_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire oled_dpf_pkg::head_t              head_i,
  output logic                                  pop_o,
  input  wire logic [oled_dpf_pkg::DEV_W-1:0]   dev_addr_i,
  output logic                                  res_strobe_o,
  output logic                                  out_valid_o,
  output logic [oled_dpf_pkg::KIND_W-1:0]       out_kind_o,
  output logic [7:0]                            out_byte_o,
  output logic                                  out_last_o,
  output logic [oled_dpf_pkg::MASK_W-1:0]       dirty_mask_o,
  output logic                                  busy_res_o
);
  import oled_dpf_pkg::*;

  localparam logic [1:0] S_IDLE      = 2'd0;
  localparam logic [1:0] S_CMP       = 2'd1;
  localparam logic [1:0] S_CMP_TAIL  = 2'd2;
  localparam logic [1:0] S_PULL_DATA = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [PAGES-1:0]  dirty_q, dirty_d;
  logic              shadow_valid_q, shadow_valid_d;
  logic [CMD_W-1:0]  cmd_cnt_q, cmd_cnt_d;
  logic [K_W-1:0]    k_q, k_d;
  logic [COL_W-1:0]  idx_q, idx_d;
  logic [PAGE_W-1:0] cmp_page_q, cmp_page_d;
  logic [COL_W-1:0]  cmp_col_q, cmp_col_d;
  logic              rd_vld_q, rd_vld_d;
  logic [PAGE_W-1:0] rd_page_q, rd_page_d;
  logic [ADDR_W-1:0] pull_addr_q, pull_addr_d;
  logic [PAGE_W-1:0] pull_page_q, pull_page_d;

  logic              res_strobe_q, res_strobe_d;
  logic              res_valid_q, res_valid_d;
  kind_e             res_kind_q, res_kind_d;
  logic [7:0]        res_byte_q, res_byte_d;
  logic              res_last_q, res_last_d;
  logic [MASK_W-1:0] res_mask_q, res_mask_d;
  logic              res_busy_q, res_busy_d;

  logic              fr_we, sh_we;
  logic [ADDR_W-1:0] fr_waddr, fr_raddr, sh_waddr, sh_raddr;
  logic [7:0]        fr_wdata, sh_wdata, fr_rdata, sh_rdata;

  logic [PAGE_W-1:0] low_p;
  logic [ADDR_W-1:0] pull_addr, cmp_addr;
  logic              emit;

  function automatic logic [PAGE_W-1:0] lowest_dirty(input logic [PAGES-1:0] d);
    logic [PAGE_W-1:0] p;
    p = '0;
    for (int i = PAGES - 1; i >= 0; i--) begin
      if (d[i]) p = PAGE_W'(i);
    end
    return p;
  endfunction

  // Addressing sequence: page range p..p, column range 0..PAGE_BYTES-1.
  function automatic logic [7:0] addr_cmd(input logic [CMD_W-1:0] pos,
                                          input logic [PAGE_W-1:0] p);
    logic [7:0] b;
    case (pos)
      CMD_W'(0): b = CMD_PAGE_ADDR;
      CMD_W'(1), CMD_W'(2): b = 8'(p);
      CMD_W'(3): b = CMD_COL_ADDR;
      CMD_W'(5): b = 8'(PAGE_BYTES - 1);
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

  assign low_p     = lowest_dirty(dirty_q);
  assign pull_addr = ADDR_W'(int'(low_p) * PAGE_BYTES + int'(idx_q));
  assign cmp_addr  = ADDR_W'(int'(cmp_page_q) * PAGE_BYTES + int'(cmp_col_q));

  always_comb begin
    state_d        = state_q;
    dirty_d        = dirty_q;
    shadow_valid_d = shadow_valid_q;
    cmd_cnt_d      = cmd_cnt_q;
    k_d            = k_q;
    idx_d          = idx_q;
    cmp_page_d     = cmp_page_q;
    cmp_col_d      = cmp_col_q;
    rd_vld_d       = 1'b0;
    rd_page_d      = rd_page_q;
    pull_addr_d    = pull_addr_q;
    pull_page_d    = pull_page_q;
    pop_o          = 1'b0;
    emit           = 1'b0;
    res_valid_d    = 1'b0;
    res_kind_d     = KIND_CMD;
    res_byte_d     = 8'h00;
    res_last_d     = 1'b0;
    fr_we          = 1'b0;
    fr_waddr       = head_i.item.addr;
    fr_wdata       = head_i.item.pixel;
    fr_raddr       = cmp_addr;
    sh_we          = 1'b0;
    sh_waddr       = pull_addr_q;
    sh_wdata       = fr_rdata;
    sh_raddr       = cmp_addr;

    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          emit  = 1'b1;
          case (head_i.item.op)
            OP_LOAD: begin
              fr_we = (dirty_q == '0) && head_i.item.load_ok;
            end
            OP_END_FRAME: begin
              if (dirty_q == '0) begin
                cmd_cnt_d = '0;
                k_d       = '0;
                idx_d     = '0;
                if (!shadow_valid_q) begin
                  dirty_d        = '1;
                  shadow_valid_d = 1'b1;
                end else begin
                  emit       = 1'b0;
                  state_d    = S_CMP;
                  cmp_page_d = '0;
                  cmp_col_d  = '0;
                end
              end
            end
            OP_PULL: begin
              if (dirty_q == '0) begin
                // nothing pending
              end else if (dev_addr_i == '0) begin
                dirty_d   = '0;
                cmd_cnt_d = '0;
                k_d       = '0;
                idx_d     = '0;
              end else if (cmd_cnt_q < CMD_W'(CMD_BYTES)) begin
                res_valid_d = 1'b1;
                res_kind_d  = KIND_CMD;
                res_byte_d  = addr_cmd(cmd_cnt_q, low_p);
                res_last_d  = 1'b1;
                cmd_cnt_d   = cmd_cnt_q + 1'b1;
              end else if (k_q == '0) begin
                res_valid_d = 1'b1;
                res_kind_d  = KIND_CTRL;
                res_byte_d  = CTRL_DATA;
                k_d         = K_W'(1);
              end else begin
                emit        = 1'b0;
                fr_raddr    = pull_addr;
                pull_addr_d = pull_addr;
                pull_page_d = low_p;
                state_d     = S_PULL_DATA;
              end
            end
            OP_INVALIDATE: begin
              shadow_valid_d = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_CMP: begin
        // one address per cycle; the compare lands in the cycle after its read
        rd_vld_d  = 1'b1;
        rd_page_d = cmp_page_q;
        if (rd_vld_q && (fr_rdata != sh_rdata)) begin
          dirty_d[rd_page_q] = 1'b1;
        end
        if (cmp_col_q == COL_W'(PAGE_BYTES - 1)) begin
          cmp_col_d = '0;
          if (cmp_page_q == PAGE_W'(PAGES - 1)) begin
            state_d = S_CMP_TAIL;
          end else begin
            cmp_page_d = cmp_page_q + 1'b1;
          end
        end else begin
          cmp_col_d = cmp_col_q + 1'b1;
        end
      end
      S_CMP_TAIL: begin
        if (rd_vld_q && (fr_rdata != sh_rdata)) begin
          dirty_d[rd_page_q] = 1'b1;
        end
        shadow_valid_d = 1'b1;
        emit           = 1'b1;
        state_d        = S_IDLE;
      end
      S_PULL_DATA: begin
        sh_we       = 1'b1;
        emit        = 1'b1;
        res_valid_d = 1'b1;
        res_kind_d  = KIND_DATA;
        res_byte_d  = fr_rdata;
        res_last_d  = (k_q == K_W'(CHUNK_BYTES)) || (idx_q == COL_W'(PAGE_BYTES - 1));
        if (idx_q == COL_W'(PAGE_BYTES - 1)) begin
          dirty_d[pull_page_q] = 1'b0;
          cmd_cnt_d            = '0;
          k_d                  = '0;
          idx_d                = '0;
        end else begin
          idx_d = idx_q + 1'b1;
          k_d   = (k_q == K_W'(CHUNK_BYTES)) ? '0 : k_q + 1'b1;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_strobe_d = emit;
    res_mask_d   = MASK_W'(dirty_d);
    res_busy_d   = |dirty_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      dirty_q        <= '0;
      shadow_valid_q <= 1'b0;
      cmd_cnt_q      <= '0;
      k_q            <= '0;
      idx_q          <= '0;
      rd_vld_q       <= 1'b0;
      res_strobe_q   <= 1'b0;
    end else begin
      state_q        <= state_d;
      dirty_q        <= dirty_d;
      shadow_valid_q <= shadow_valid_d;
      cmd_cnt_q      <= cmd_cnt_d;
      k_q            <= k_d;
      idx_q          <= idx_d;
      rd_vld_q       <= rd_vld_d;
      res_strobe_q   <= res_strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_page_q  <= cmp_page_d;
    cmp_col_q   <= cmp_col_d;
    rd_page_q   <= rd_page_d;
    pull_addr_q <= pull_addr_d;
    pull_page_q <= pull_page_d;
    res_valid_q <= res_valid_d;
    res_kind_q  <= res_kind_d;
    res_byte_q  <= res_byte_d;
    res_last_q  <= res_last_d;
    res_mask_q  <= res_mask_d;
    res_busy_q  <= res_busy_d;
  end

  oled_dpf_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  oled_dpf_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_shadow_ram (
    .clk_i   (clk_i),
    .we_i    (sh_we),
    .waddr_i (sh_waddr),
    .wdata_i (sh_wdata),
    .raddr_i (sh_raddr),
    .rdata_o (sh_rdata)
  );

  assign res_strobe_o = res_strobe_q;
  assign out_valid_o  = res_valid_q;
  assign out_kind_o   = res_kind_q;
  assign out_byte_o   = res_byte_q;
  assign out_last_o   = res_last_q;
  assign dirty_mask_o = res_mask_q;
  assign busy_res_o   = res_busy_q;

endmodule
`default_nettype wire
